/* rtl/pthc_pkg.sv */
// Package: shared types, constants and the microprogram of the compensation engine.
`timescale 1ns / 1ps
package pthc_pkg;

  localparam int PC_W        = 7;
  localparam int MUL_DIGIT   = 4;
  localparam int MUL_STEPS   = 64 / MUL_DIGIT;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [23:0] DISABLED_24 = 24'h800000;
  localparam logic [15:0] DISABLED_16 = 16'h8000;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_LDK, OP_LDP, OP_ADD, OP_SUB, OP_MUL, OP_MULP, OP_DIVP, OP_DIV,
    OP_FT, OP_OUTT, OP_PCHK, OP_OUTP, OP_QCHK, OP_OUTH, OP_END
  } op_e;

  typedef enum logic [2:0] {R0, R1, R2, R3, R4, R5, R6, R7} reg_e;

  // operand sources for OP_LDK
  typedef enum logic [4:0] {
    K_ADC_T, K_ADC_P, K_RAW_H, K_FT,
    K_T1, K_T2, K_T3,
    K_P1, K_P2, K_P3, K_P4, K_P5, K_P6, K_P7, K_P8, K_P9,
    K_H1, K_H2, K_H3, K_H4, K_H5, K_H6,
    K_C5, K_C128000, K_C3125, K_C76800
  } k_e;

  typedef struct packed {
    op_e        op;
    reg_e       d;
    reg_e       a;
    reg_e       b;
    logic [5:0] imm;
  } uinst_t;

  function automatic uinst_t mk(op_e op, reg_e d, reg_e a, reg_e b, logic [5:0] imm);
    uinst_t u;
    u.op  = op;
    u.d   = d;
    u.a   = a;
    u.b   = b;
    u.imm = imm;
    return u;
  endfunction

  function automatic logic [5:0] kc(k_e k);
    return {1'b0, k};
  endfunction

  // signed division by 2**n, truncating toward zero
  function automatic logic [63:0] div_pow2(logic [63:0] a, logic [5:0] n);
    logic [63:0] bias;
    bias = a[63] ? ((64'd1 << n) - 64'd1) : 64'd0;
    return 64'($signed(a + bias) >>> n);
  endfunction

  // microprogram: temperature, then pressure, then humidity
  function automatic uinst_t prog_rom(logic [PC_W-1:0] pc);
    case (pc)
      // temperature
      7'd0:   return mk(OP_LDK,  R0, R0, R0, kc(K_ADC_T));
      7'd1:   return mk(OP_DIVP, R0, R0, R0, 6'd3);
      7'd2:   return mk(OP_LDK,  R1, R0, R0, kc(K_T1));
      7'd3:   return mk(OP_ADD,  R2, R1, R1, 6'd0);
      7'd4:   return mk(OP_SUB,  R0, R0, R2, 6'd0);
      7'd5:   return mk(OP_LDK,  R2, R0, R0, kc(K_T2));
      7'd6:   return mk(OP_MUL,  R0, R0, R2, 6'd0);
      7'd7:   return mk(OP_DIVP, R0, R0, R0, 6'd11);
      7'd8:   return mk(OP_LDK,  R2, R0, R0, kc(K_ADC_T));
      7'd9:   return mk(OP_DIVP, R2, R2, R0, 6'd4);
      7'd10:  return mk(OP_SUB,  R2, R2, R1, 6'd0);
      7'd11:  return mk(OP_MUL,  R2, R2, R2, 6'd0);
      7'd12:  return mk(OP_DIVP, R2, R2, R0, 6'd12);
      7'd13:  return mk(OP_LDK,  R3, R0, R0, kc(K_T3));
      7'd14:  return mk(OP_MUL,  R2, R2, R3, 6'd0);
      7'd15:  return mk(OP_DIVP, R2, R2, R0, 6'd14);
      7'd16:  return mk(OP_ADD,  R0, R0, R2, 6'd0);
      7'd17:  return mk(OP_FT,   R0, R0, R0, 6'd0);
      7'd18:  return mk(OP_LDK,  R0, R0, R0, kc(K_FT));
      7'd19:  return mk(OP_LDK,  R1, R0, R0, kc(K_C5));
      7'd20:  return mk(OP_MUL,  R0, R0, R1, 6'd0);
      7'd21:  return mk(OP_LDP,  R1, R0, R0, 6'd7);
      7'd22:  return mk(OP_ADD,  R0, R0, R1, 6'd0);
      7'd23:  return mk(OP_DIVP, R0, R0, R0, 6'd8);
      7'd24:  return mk(OP_OUTT, R0, R0, R0, 6'd0);
      // pressure
      7'd25:  return mk(OP_LDK,  R0, R0, R0, kc(K_FT));
      7'd26:  return mk(OP_LDK,  R1, R0, R0, kc(K_C128000));
      7'd27:  return mk(OP_SUB,  R0, R0, R1, 6'd0);
      7'd28:  return mk(OP_MUL,  R1, R0, R0, 6'd0);
      7'd29:  return mk(OP_LDK,  R2, R0, R0, kc(K_P6));
      7'd30:  return mk(OP_MUL,  R2, R1, R2, 6'd0);
      7'd31:  return mk(OP_LDK,  R3, R0, R0, kc(K_P5));
      7'd32:  return mk(OP_MUL,  R3, R0, R3, 6'd0);
      7'd33:  return mk(OP_MULP, R3, R3, R0, 6'd17);
      7'd34:  return mk(OP_ADD,  R2, R2, R3, 6'd0);
      7'd35:  return mk(OP_LDK,  R3, R0, R0, kc(K_P4));
      7'd36:  return mk(OP_MULP, R3, R3, R0, 6'd35);
      7'd37:  return mk(OP_ADD,  R2, R2, R3, 6'd0);
      7'd38:  return mk(OP_LDK,  R3, R0, R0, kc(K_P3));
      7'd39:  return mk(OP_MUL,  R3, R1, R3, 6'd0);
      7'd40:  return mk(OP_DIVP, R3, R3, R0, 6'd8);
      7'd41:  return mk(OP_LDK,  R4, R0, R0, kc(K_P2));
      7'd42:  return mk(OP_MUL,  R4, R0, R4, 6'd0);
      7'd43:  return mk(OP_MULP, R4, R4, R0, 6'd12);
      7'd44:  return mk(OP_ADD,  R3, R3, R4, 6'd0);
      7'd45:  return mk(OP_LDP,  R4, R0, R0, 6'd47);
      7'd46:  return mk(OP_ADD,  R3, R4, R3, 6'd0);
      7'd47:  return mk(OP_LDK,  R4, R0, R0, kc(K_P1));
      7'd48:  return mk(OP_MUL,  R3, R3, R4, 6'd0);
      7'd49:  return mk(OP_DIVP, R3, R3, R0, 6'd33);
      7'd50:  return mk(OP_PCHK, R0, R3, R0, 6'd0);
      7'd51:  return mk(OP_LDP,  R4, R0, R0, 6'd20);
      7'd52:  return mk(OP_LDK,  R5, R0, R0, kc(K_ADC_P));
      7'd53:  return mk(OP_SUB,  R4, R4, R5, 6'd0);
      7'd54:  return mk(OP_MULP, R4, R4, R0, 6'd31);
      7'd55:  return mk(OP_SUB,  R4, R4, R2, 6'd0);
      7'd56:  return mk(OP_LDK,  R5, R0, R0, kc(K_C3125));
      7'd57:  return mk(OP_MUL,  R4, R4, R5, 6'd0);
      7'd58:  return mk(OP_DIV,  R4, R4, R3, 6'd0);
      7'd59:  return mk(OP_DIVP, R6, R4, R0, 6'd13);
      7'd60:  return mk(OP_LDK,  R5, R0, R0, kc(K_P9));
      7'd61:  return mk(OP_MUL,  R5, R5, R6, 6'd0);
      7'd62:  return mk(OP_MUL,  R5, R5, R6, 6'd0);
      7'd63:  return mk(OP_DIVP, R5, R5, R0, 6'd25);
      7'd64:  return mk(OP_LDK,  R6, R0, R0, kc(K_P8));
      7'd65:  return mk(OP_MUL,  R6, R6, R4, 6'd0);
      7'd66:  return mk(OP_DIVP, R6, R6, R0, 6'd19);
      7'd67:  return mk(OP_ADD,  R4, R4, R5, 6'd0);
      7'd68:  return mk(OP_ADD,  R4, R4, R6, 6'd0);
      7'd69:  return mk(OP_DIVP, R4, R4, R0, 6'd8);
      7'd70:  return mk(OP_LDK,  R5, R0, R0, kc(K_P7));
      7'd71:  return mk(OP_MULP, R5, R5, R0, 6'd4);
      7'd72:  return mk(OP_ADD,  R4, R4, R5, 6'd0);
      7'd73:  return mk(OP_OUTP, R0, R4, R0, 6'd0);
      // humidity
      7'd74:  return mk(OP_LDK,  R0, R0, R0, kc(K_FT));
      7'd75:  return mk(OP_LDK,  R1, R0, R0, kc(K_C76800));
      7'd76:  return mk(OP_SUB,  R0, R0, R1, 6'd0);
      7'd77:  return mk(OP_LDK,  R1, R0, R0, kc(K_RAW_H));
      7'd78:  return mk(OP_MULP, R1, R1, R0, 6'd14);
      7'd79:  return mk(OP_LDK,  R2, R0, R0, kc(K_H4));
      7'd80:  return mk(OP_MULP, R2, R2, R0, 6'd20);
      7'd81:  return mk(OP_SUB,  R1, R1, R2, 6'd0);
      7'd82:  return mk(OP_LDK,  R2, R0, R0, kc(K_H5));
      7'd83:  return mk(OP_MUL,  R2, R2, R0, 6'd0);
      7'd84:  return mk(OP_SUB,  R1, R1, R2, 6'd0);
      7'd85:  return mk(OP_LDP,  R2, R0, R0, 6'd14);
      7'd86:  return mk(OP_ADD,  R1, R1, R2, 6'd0);
      7'd87:  return mk(OP_DIVP, R1, R1, R0, 6'd15);
      7'd88:  return mk(OP_LDK,  R2, R0, R0, kc(K_H6));
      7'd89:  return mk(OP_MUL,  R2, R0, R2, 6'd0);
      7'd90:  return mk(OP_DIVP, R2, R2, R0, 6'd10);
      7'd91:  return mk(OP_LDK,  R3, R0, R0, kc(K_H3));
      7'd92:  return mk(OP_MUL,  R3, R0, R3, 6'd0);
      7'd93:  return mk(OP_DIVP, R3, R3, R0, 6'd11);
      7'd94:  return mk(OP_LDP,  R4, R0, R0, 6'd15);
      7'd95:  return mk(OP_ADD,  R3, R3, R4, 6'd0);
      7'd96:  return mk(OP_MUL,  R2, R2, R3, 6'd0);
      7'd97:  return mk(OP_DIVP, R2, R2, R0, 6'd10);
      7'd98:  return mk(OP_LDP,  R3, R0, R0, 6'd21);
      7'd99:  return mk(OP_ADD,  R2, R2, R3, 6'd0);
      7'd100: return mk(OP_LDK,  R3, R0, R0, kc(K_H2));
      7'd101: return mk(OP_MUL,  R2, R2, R3, 6'd0);
      7'd102: return mk(OP_LDP,  R3, R0, R0, 6'd13);
      7'd103: return mk(OP_ADD,  R2, R2, R3, 6'd0);
      7'd104: return mk(OP_DIVP, R2, R2, R0, 6'd14);
      7'd105: return mk(OP_MUL,  R1, R1, R2, 6'd0);
      7'd106: return mk(OP_DIVP, R2, R1, R0, 6'd15);
      7'd107: return mk(OP_QCHK, R0, R2, R0, 6'd0);
      7'd108: return mk(OP_MUL,  R2, R2, R2, 6'd0);
      7'd109: return mk(OP_DIVP, R2, R2, R0, 6'd7);
      7'd110: return mk(OP_LDK,  R3, R0, R0, kc(K_H1));
      7'd111: return mk(OP_MUL,  R2, R2, R3, 6'd0);
      7'd112: return mk(OP_DIVP, R2, R2, R0, 6'd4);
      7'd113: return mk(OP_SUB,  R2, R1, R2, 6'd0);
      7'd114: return mk(OP_OUTH, R0, R1, R2, 6'd0);
      default: return mk(OP_END, R0, R0, R0, 6'd0);
    endcase
  endfunction

endpackage

/* rtl/pthc_if.sv */
// Interfaces: raw sample channel and compensated result channel.
`timescale 1ns / 1ps
interface pthc_raw_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface pthc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_centi;
  logic               temperature_valid;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;
  logic        [16:0] humidity_q22_10;
  logic               humidity_valid;

  modport source (output valid, temperature_centi, temperature_valid, pressure_q24_8,
                  pressure_valid, humidity_q22_10, humidity_valid, input ready);
  modport sink   (input valid, temperature_centi, temperature_valid, pressure_q24_8,
                  pressure_valid, humidity_q22_10, humidity_valid, output ready);
endinterface

/* rtl/pthc_mul.sv */
// Digit-serial 64x64 multiplier, low 64 bits of the product, one 4-bit digit per cycle.
`timescale 1ns / 1ps
module pthc_mul
  import pthc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic                 busy_q, done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [63:0]          a_q, b_q, acc_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift-add: multiplicand moves up one digit, multiplier down one digit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + a_q * 64'(b_q[MUL_DIGIT-1:0]);
      a_q   <= a_q << MUL_DIGIT;
      b_q   <= b_q >> MUL_DIGIT;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* rtl/pthc_div.sv */
// Bit-serial signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module pthc_div
  import pthc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  logic                 busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [63:0]          rem_q, quo_q, dm_q;
  logic [64:0]          shifted, trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // restoring step on magnitudes
  assign shifted = {rem_q, quo_q[63]};
  assign trial   = shifted - {1'b0, dm_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= n_i[63] ^ d_i[63];
      quo_q <= n_i[63] ? (64'd0 - n_i) : n_i;
      dm_q  <= d_i[63] ? (64'd0 - d_i) : d_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= shifted[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

/* rtl/pth_sensor_compensation_top.sv */
// Top level: config registers, microcoded sequencer, register file and result register.
//
//  channel  | dir | transfer condition          | payload
//  raw_i    | in  | raw_i.valid & raw_i.ready   | raw pressure, temperature, humidity
//  res_o    | out | res_o.valid & res_o.ready   | temperature, pressure, humidity + valids
//  cfg      | in  | cfg_we_i                    | cfg_idx_i selects, cfg_wdata_i data
//
// Each sample runs 115 micro-ops, including 22 multiplies in the 4-bit digit-serial
// multiplier and one 64-step divide. A new sample is taken only while the sequencer
// is idle; the finished result sits in the output register, so the next sample can
// start while it waits for res_o.ready.
// Reset clears the configuration registers and the stored fine temperature.
`timescale 1ns / 1ps
module pth_sensor_compensation_top
  import pthc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  pthc_raw_if.sink    raw_i,
  pthc_res_if.source  res_o
);

  state_e state_q, state_d;
  logic [PC_W-1:0] pc_q;
  uinst_t inst;

  logic [47:0] tc_q, pa_q, pb_q, pc_coef_q;
  logic [63:0] hc_q;
  logic signed [31:0] ft_q;

  logic [23:0] rp_q, rt_q;
  logic [15:0] rh_q;
  logic t_en_q, p_en_q, h_en_q;
  logic pzero_q, qbig_q;

  logic [63:0] rf_mem [8];
  logic [63:0] rda_q, rdb_q;
  logic [63:0] alu_res, ksrc, wb_data;

  logic mul_done, div_done;
  logic [63:0] mul_p, div_q;

  logic signed [15:0] t_stage_q;
  logic [31:0] p_stage_q;
  logic [16:0] h_stage_q;

  logic res_valid_q;

  // control struct from the sequencer
  typedef struct packed {
    logic in_ready;
    logic mul_start;
    logic div_start;
    logic rf_we;
    logic pc_inc;
    logic res_load;
  } ctrl_t;
  ctrl_t ctl;

  logic is_unit, is_write;
  logic accept;

  assign inst    = prog_rom(pc_q);
  assign is_unit = (inst.op == OP_MUL) || (inst.op == OP_DIV);
  assign is_write = (inst.op == OP_LDK) || (inst.op == OP_LDP) || (inst.op == OP_ADD) ||
                    (inst.op == OP_SUB) || (inst.op == OP_MULP) || (inst.op == OP_DIVP);
  assign accept  = raw_i.valid && ctl.in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q      <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      pc_coef_q <= '0;
      hc_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:    tc_q      <= cfg_wdata_i[47:0];
        CFG_PRESS_A: pa_q      <= cfg_wdata_i[47:0];
        CFG_PRESS_B: pb_q      <= cfg_wdata_i[47:0];
        CFG_PRESS_C: pc_coef_q <= cfg_wdata_i[47:0];
        CFG_HUM:     hc_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (raw_i.valid) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (is_unit) state_d = S_WAIT;
        else if (inst.op == OP_END) state_d = S_DONE;
        else state_d = S_READ;
      end
      S_WAIT: if (mul_done || div_done) state_d = S_READ;
      S_DONE: if (!res_valid_q || res_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl = '0;
    case (state_q)
      S_IDLE: ctl.in_ready = 1'b1;
      S_EXEC: begin
        ctl.mul_start = (inst.op == OP_MUL);
        ctl.div_start = (inst.op == OP_DIV);
        ctl.rf_we     = is_write;
        ctl.pc_inc    = !is_unit && (inst.op != OP_END);
      end
      S_WAIT: begin
        ctl.rf_we  = mul_done || div_done;
        ctl.pc_inc = mul_done || div_done;
      end
      S_DONE: ctl.res_load = !res_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) pc_q <= '0;
      else if (ctl.pc_inc) pc_q <= pc_q + 1'b1;
    end
  end

  // capture the raw sample
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rp_q   <= raw_i.raw_pressure;
      rt_q   <= raw_i.raw_temperature;
      rh_q   <= raw_i.raw_humidity;
      t_en_q <= raw_i.raw_temperature != DISABLED_24;
      p_en_q <= raw_i.raw_pressure != DISABLED_24;
      h_en_q <= raw_i.raw_humidity != DISABLED_16;
    end
  end

  // operand load sources
  always_comb begin
    case (k_e'(inst.imm[4:0]))
      K_ADC_T:   ksrc = {44'd0, rt_q[23:4]};
      K_ADC_P:   ksrc = {44'd0, rp_q[23:4]};
      K_RAW_H:   ksrc = {48'd0, rh_q};
      K_FT:      ksrc = {{32{ft_q[31]}}, ft_q};
      K_T1:      ksrc = {48'd0, tc_q[15:0]};
      K_T2:      ksrc = {{48{tc_q[31]}}, tc_q[31:16]};
      K_T3:      ksrc = {{48{tc_q[47]}}, tc_q[47:32]};
      K_P1:      ksrc = {48'd0, pa_q[15:0]};
      K_P2:      ksrc = {{48{pa_q[31]}}, pa_q[31:16]};
      K_P3:      ksrc = {{48{pa_q[47]}}, pa_q[47:32]};
      K_P4:      ksrc = {{48{pb_q[15]}}, pb_q[15:0]};
      K_P5:      ksrc = {{48{pb_q[31]}}, pb_q[31:16]};
      K_P6:      ksrc = {{48{pb_q[47]}}, pb_q[47:32]};
      K_P7:      ksrc = {{48{pc_coef_q[15]}}, pc_coef_q[15:0]};
      K_P8:      ksrc = {{48{pc_coef_q[31]}}, pc_coef_q[31:16]};
      K_P9:      ksrc = {{48{pc_coef_q[47]}}, pc_coef_q[47:32]};
      K_H1:      ksrc = {56'd0, hc_q[7:0]};
      K_H2:      ksrc = {{48{hc_q[23]}}, hc_q[23:8]};
      K_H3:      ksrc = {56'd0, hc_q[31:24]};
      K_H4:      ksrc = {{52{hc_q[43]}}, hc_q[43:32]};
      K_H5:      ksrc = {{52{hc_q[55]}}, hc_q[55:44]};
      K_H6:      ksrc = {{56{hc_q[63]}}, hc_q[63:56]};
      K_C5:      ksrc = 64'd5;
      K_C128000: ksrc = 64'd128000;
      K_C3125:   ksrc = 64'd3125;
      K_C76800:  ksrc = 64'd76800;
      default:   ksrc = '0;
    endcase
  end

  // combinational ALU ops
  always_comb begin
    case (inst.op)
      OP_LDK:  alu_res = ksrc;
      OP_LDP:  alu_res = 64'd1 << inst.imm;
      OP_ADD:  alu_res = rda_q + rdb_q;
      OP_SUB:  alu_res = rda_q - rdb_q;
      OP_MULP: alu_res = rda_q << inst.imm;
      OP_DIVP: alu_res = div_pow2(rda_q, inst.imm);
      default: alu_res = '0;
    endcase
  end

  assign wb_data = (state_q == S_WAIT) ? ((inst.op == OP_DIV) ? div_q : mul_p) : alu_res;

  // register file, registered reads
  always_ff @(posedge clk_i) begin
    if (ctl.rf_we) rf_mem[inst.d] <= wb_data;
    rda_q <= rf_mem[inst.a];
    rdb_q <= rf_mem[inst.b];
  end

  pthc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (rda_q),
    .b_i     (rdb_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pthc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .n_i     (rda_q),
    .d_i     (rdb_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // fine temperature, kept across samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= '0;
    end else if (state_q == S_EXEC && inst.op == OP_FT && t_en_q) begin
      ft_q <= rda_q[31:0];
    end
  end

  // result staging: saturation and clamps
  logic signed [63:0] sa, sb, hsel;
  assign sa = rda_q;
  assign sb = rdb_q;

  always_comb begin
    if (hc_q[7:0] == 8'd0) hsel = sa;
    else if (qbig_q) hsel = -64'sd1;
    else hsel = sb;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      case (inst.op)
        OP_OUTT: begin
          if (sa > 64'sd32767) t_stage_q <= 16'sh7fff;
          else if (sa < -64'sd32768) t_stage_q <= 16'sh8000;
          else t_stage_q <= sa[15:0];
        end
        OP_PCHK: pzero_q <= (rda_q == 64'd0);
        OP_OUTP: begin
          if (pzero_q || rda_q[63]) p_stage_q <= 32'd0;
          else if (rda_q[62:32] != 31'd0) p_stage_q <= 32'hffff_ffff;
          else p_stage_q <= rda_q[31:0];
        end
        OP_QCHK: qbig_q <= (sa >= 64'sd134217728) || (sa <= -64'sd134217728);
        OP_OUTH: begin
          if (hsel < 64'sd0) h_stage_q <= 17'd0;
          else if (hsel > 64'sd419430400) h_stage_q <= 17'd102400;
          else h_stage_q <= hsel[28:12];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (ctl.res_load) res_valid_q <= 1'b1;
    else if (res_o.ready) res_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.res_load) begin
      res_o.temperature_centi <= t_en_q ? t_stage_q : 16'sd0;
      res_o.temperature_valid <= t_en_q;
      res_o.pressure_q24_8    <= p_en_q ? p_stage_q : 32'd0;
      res_o.pressure_valid    <= p_en_q;
      res_o.humidity_q22_10   <= h_en_q ? h_stage_q : 17'd0;
      res_o.humidity_valid    <= h_en_q;
    end
  end

  assign res_o.valid = res_valid_q;
  assign raw_i.ready = ctl.in_ready;

  // checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ && pc_q == '0))
    else $error("accepted sample did not start the program");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done || div_done) |-> (state_q == S_WAIT))
    else $error("arithmetic unit finished outside wait state");

  a_ft_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ft_q != $past(ft_q)) |-> $past(state_q == S_EXEC && inst.op == OP_FT && t_en_q))
    else $error("fine temperature changed without an enabled update");

  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.res_load |=> res_valid_q)
    else $error("result load lost");

endmodule

/* verif/pth_sensor_compensation_top_test.sv */
// Testbench: compensation block against a cycle-free predictor, random idling on both channels.
`timescale 1ns / 1ps
module pth_sensor_compensation_top_test
  import pthc_pkg::*;
();

  localparam int  LIMIT_CYCLES = 6_000_000;
  localparam int  DRAIN_CYCLES = 800;
  localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic signed [15:0] temp;
    logic               temp_ok;
    logic        [31:0] press;
    logic               press_ok;
    logic        [16:0] hum;
    logic               hum_ok;
  } comp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_wdata;

  pthc_raw_if raw_if ();
  pthc_res_if res_if ();

  pth_sensor_compensation_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .raw_i       (raw_if.sink),
    .res_o       (res_if.source)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block's coefficients and stored fine temperature
  logic [63:0]  coef_q [5];
  int           fine_temp;
  comp_result_t pending_results[$];
  int           mismatches = 0;
  int           cycle_cnt = 0;
  int           burst_left = 0;
  int           stall_pct = 0;

  // signed 64-bit divide on wrapped values, truncating toward zero
  function automatic logic [63:0] wrap_div(logic [63:0] a, logic [63:0] d);
    logic [63:0] ma, md, q;
    ma = a[63] ? -a : a;
    md = d[63] ? -d : d;
    q  = ma / md;
    return (a[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic signed [15:0] comp_temperature(logic [23:0] raw);
    longint adc, t1, t2, t3, v1, v2, t;
    adc = raw >> 4;
    t1  = coef_q[CFG_TEMP][15:0];
    t2  = $signed(coef_q[CFG_TEMP][31:16]);
    t3  = $signed(coef_q[CFG_TEMP][47:32]);
    v1  = ((adc / 8) - t1 * 2) * t2 / 2048;
    v2  = (adc / 16) - t1;
    v2  = ((v2 * v2) / 4096) * t3 / 16384;
    fine_temp = int'(v1 + v2);
    t = (longint'(fine_temp) * 5 + 128) / 256;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  // 64-bit wrapping datapath
  function automatic logic [31:0] comp_pressure(logic [23:0] raw);
    logic [63:0] adc, p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, d, r;
    longint s;
    adc = 64'(raw >> 4);
    p1 = 64'(coef_q[CFG_PRESS_A][15:0]);
    s = $signed(coef_q[CFG_PRESS_A][31:16]); p2 = s;
    s = $signed(coef_q[CFG_PRESS_A][47:32]); p3 = s;
    s = $signed(coef_q[CFG_PRESS_B][15:0]);  p4 = s;
    s = $signed(coef_q[CFG_PRESS_B][31:16]); p5 = s;
    s = $signed(coef_q[CFG_PRESS_B][47:32]); p6 = s;
    s = $signed(coef_q[CFG_PRESS_C][15:0]);  p7 = s;
    s = $signed(coef_q[CFG_PRESS_C][31:16]); p8 = s;
    s = $signed(coef_q[CFG_PRESS_C][47:32]); p9 = s;
    s = longint'(fine_temp) - 128000;
    a = s;
    b = a * a * p6;
    b = b + a * p5 * 64'd131072;
    b = b + p4 * 64'd34359738368;
    a = wrap_div(a * a * p3, 64'd256) + a * p2 * 64'd4096;
    a = wrap_div((64'd140737488355328 + a) * p1, 64'd8589934592);
    if (a == 64'd0) return 32'd0;
    d = 64'd1048576 - adc;
    d = wrap_div((d * 64'd2147483648 - b) * 64'd3125, a);
    a = wrap_div(p9 * wrap_div(d, 64'd8192) * wrap_div(d, 64'd8192), 64'd33554432);
    b = wrap_div(p8 * d, 64'd524288);
    r = wrap_div(d + a + b, 64'd256) + p7 * 64'd16;
    if (r[63]) return 32'd0;
    if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return r[31:0];
  endfunction

  function automatic logic [16:0] comp_humidity(logic [15:0] raw);
    longint h1, h2, h3, h4, h5, h6, v1, v2, v3, v4, v5, q;
    h1 = coef_q[CFG_HUM][7:0];
    h2 = $signed(coef_q[CFG_HUM][23:8]);
    h3 = coef_q[CFG_HUM][31:24];
    h4 = $signed(coef_q[CFG_HUM][43:32]);
    h5 = $signed(coef_q[CFG_HUM][55:44]);
    h6 = $signed(coef_q[CFG_HUM][63:56]);
    v1 = longint'(fine_temp) - 76800;
    v2 = longint'(raw) * 16384;
    v3 = h4 * 1048576;
    v4 = h5 * v1;
    v5 = (((v2 - v3) - v4) + 16384) / 32768;
    v2 = (v1 * h6) / 1024;
    v3 = (v1 * h3) / 2048;
    v4 = ((v2 * (v3 + 32768)) / 1024) + 2097152;
    v2 = ((v4 * h2) + 8192) / 16384;
    v3 = v5 * v2;
    q  = v3 / 32768;
    // squared term out of 64-bit range only when the result is negative
    if (h1 == 0) v5 = v3;
    else if (q >= 134217728 || q <= -134217728) v5 = -1;
    else v5 = v3 - (((q * q) / 128) * h1) / 16;
    if (v5 < 0) v5 = 0;
    if (v5 > 419430400) v5 = 419430400;
    return 17'(v5 / 4096);
  endfunction

  // temperature first: it updates the fine temperature used by the others
  function automatic comp_result_t compensate(logic [23:0] rp, logic [23:0] rt,
                                              logic [15:0] rh);
    comp_result_t r;
    r = '{default: '0};
    if (rt != DISABLED_24) begin
      r.temp = comp_temperature(rt);
      r.temp_ok = 1'b1;
    end
    if (rp != DISABLED_24) begin
      r.press = comp_pressure(rp);
      r.press_ok = 1'b1;
    end
    if (rh != DISABLED_16) begin
      r.hum = comp_humidity(rh);
      r.hum_ok = 1'b1;
    end
    return r;
  endfunction

  // one raw transfer, with bursts and gaps on the sender side
  task automatic send_sample(logic [23:0] rp, logic [23:0] rt, logic [15:0] rh);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        raw_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    raw_if.valid           <= 1'b1;
    raw_if.raw_pressure    <= rp;
    raw_if.raw_temperature <= rt;
    raw_if.raw_humidity    <= rh;
    @(posedge clk_i);
    while (!raw_if.ready) @(posedge clk_i);
    pending_results.push_back(compensate(rp, rt, rh));
  endtask

  // hold the sender until every result is back and the sequencer is idle
  task automatic drain_results();
    raw_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_coeffs(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                              logic [63:0] pc, logic [63:0] h);
    logic [63:0] vals [5];
    vals = '{t, pa, pb, pc, h};
    drain_results();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      coef_q[i] = (3'(i) == CFG_HUM) ? vals[i] : (vals[i] & M48);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // plausible ADC words, with some noise and disabled markers
  task automatic send_plausible();
    logic [23:0] rp, rt;
    logic [15:0] rh;
    rt = {20'($urandom_range(400000, 600000)), 4'($urandom())};
    rp = {20'($urandom_range(250000, 450000)), 4'($urandom())};
    rh = 16'($urandom_range(20000, 40000));
    case ($urandom_range(19))
      0: rt = DISABLED_24;
      1: rp = DISABLED_24;
      2: rh = DISABLED_16;
      3, 4: begin
        rp = 24'($urandom());
        rt = 24'($urandom());
        rh = 16'($urandom());
      end
      default: ;
    endcase
    send_sample(rp, rt, rh);
  endtask

  task automatic load_nominal();
    write_coeffs({16'(-1000), 16'd26435, 16'd27504},
                 {16'd3024, 16'(-10685), 16'd36477},
                 {16'(-7), 16'd140, 16'd2855},
                 {16'd6000, 16'(-14600), 16'd15500},
                 {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
  endtask

  // all-zero coefficients after reset: zero divisor, disabled words, extremes
  task automatic test_reset_coeffs();
    send_sample(24'h000000, 24'h000000, 16'h0000);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_sample(DISABLED_24, DISABLED_24, DISABLED_16);
    send_sample(DISABLED_24, 24'h7FFFFF, 16'h7FFF);
    send_sample(24'h7FFFFF, DISABLED_24, 16'h8001);
  endtask

  // nominal coefficients: extremes, and a disabled temperature keeping fine temperature
  task automatic test_directed_nominal();
    load_nominal();
    send_sample(24'h600000, 24'h7E0000, 16'h6800);
    send_sample(24'h600000, DISABLED_24, 16'h6800);
    send_sample(24'h000000, 24'h000000, 16'h0000);
    send_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_sample(24'hFFFFFF, DISABLED_24, 16'h0000);
    send_sample(24'h000000, 24'h80000F, 16'hFFFF);
    send_sample(24'h800001, 24'h7FFFF0, DISABLED_16);
    send_sample(DISABLED_24, 24'h000010, 16'h7FFF);
    send_sample(24'h555555, 24'hAAAAAA, 16'h5555);
    send_sample(24'hAAAAAA, 24'h555555, 16'hAAAA);
  endtask

  task automatic test_nominal_random();
    load_nominal();
    for (int n = 0; n < 560; n++) begin
      if (n == 280) drain_results();
      send_plausible();
    end
  endtask

  // coefficient extremes, including a zero pressure divisor
  task automatic test_extreme_coeffs();
    logic [63:0] sets [4][5];
    sets[0] = '{M48, M48, M48, M48, 64'hFFFF_FFFF_FFFF_FFFF};
    sets[1] = '{48'h8000_8000_FFFF, 48'h8000_8000_FFFF, 48'h8000_8000_8000,
                48'h8000_8000_8000, {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF}};
    sets[2] = '{48'h7FFF_7FFF_0000, 48'h7FFF_7FFF_0000, 48'h7FFF_7FFF_7FFF,
                48'h7FFF_7FFF_7FFF, {8'h7F, 12'h7FF, 12'h7FF, 8'h00, 16'h7FFF, 8'h00}};
    sets[3] = '{48'h0000_6000_6B70, 48'h0BD0_D643_0000, 48'h0000_0000_0000,
                48'h0000_0000_0000, 64'h0000_0000_0000_00FF};
    foreach (sets[s]) begin
      write_coeffs(sets[s][0], sets[s][1], sets[s][2], sets[s][3], sets[s][4]);
      for (int n = 0; n < 45; n++) send_plausible();
    end
  endtask

  task automatic test_random_coeffs();
    for (int s = 0; s < 10; s++) begin
      if (s % 2 == 0) write_coeffs(rand64(), rand64(), rand64(), rand64(), rand64());
      else begin
        // small perturbation of the nominal set keeps the formulas in range
        load_nominal();
        write_coeffs(coef_q[CFG_TEMP] ^ 64'($urandom_range(255)),
                     coef_q[CFG_PRESS_A] ^ 64'($urandom_range(255)),
                     coef_q[CFG_PRESS_B] ^ 64'($urandom_range(255)),
                     coef_q[CFG_PRESS_C] ^ 64'($urandom_range(255)),
                     coef_q[CFG_HUM] ^ 64'($urandom_range(255)));
      end
      for (int n = 0; n < 50; n++) send_plausible();
    end
  endtask

  // receiver: ready pattern whose stall rate is redrawn from 0, 30, 70 and 95 percent
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) begin
      case ($urandom_range(3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 70;
        default: stall_pct <= 95;
      endcase
    end
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result check on every accepted transfer
  always @(posedge clk_i) begin
    comp_result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (res_if.temperature_valid !== exp_r.temp_ok) begin
          $error("temperature_valid: expected %0d, got %0d", exp_r.temp_ok,
                 res_if.temperature_valid);
          mismatches++;
        end
        if (res_if.temperature_centi !== exp_r.temp) begin
          $error("temperature_centi: expected %0d, got %0d", exp_r.temp,
                 res_if.temperature_centi);
          mismatches++;
        end
        if (res_if.pressure_valid !== exp_r.press_ok) begin
          $error("pressure_valid: expected %0d, got %0d", exp_r.press_ok,
                 res_if.pressure_valid);
          mismatches++;
        end
        if (res_if.pressure_q24_8 !== exp_r.press) begin
          $error("pressure_q24_8: expected %0d, got %0d", exp_r.press,
                 res_if.pressure_q24_8);
          mismatches++;
        end
        if (res_if.humidity_valid !== exp_r.hum_ok) begin
          $error("humidity_valid: expected %0d, got %0d", exp_r.hum_ok,
                 res_if.humidity_valid);
          mismatches++;
        end
        if (res_if.humidity_q22_10 !== exp_r.hum) begin
          $error("humidity_q22_10: expected %0d, got %0d", exp_r.hum,
                 res_if.humidity_q22_10);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    raw_if.valid           = 1'b0;
    raw_if.raw_pressure    = '0;
    raw_if.raw_temperature = '0;
    raw_if.raw_humidity    = '0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_TEMP;
    cfg_wdata              = '0;
    foreach (coef_q[i]) coef_q[i] = '0;
    fine_temp = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_coeffs();
    test_directed_nominal();
    test_nominal_random();
    test_extreme_coeffs();
    test_random_coeffs();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
rtl/pthc_pkg.sv
rtl/pthc_if.sv
rtl/pthc_mul.sv
rtl/pthc_div.sv
rtl/pth_sensor_compensation_top.sv
verif/pth_sensor_compensation_top_test.sv
